// ===== hdl/pfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_pkg: shared types and constants of the postfix evaluator
// Stack sizing, character codes, status codes and the queue word format.
// ----------------------------------------------------------------------------
package pfe_pkg;

  // stack sizing
  localparam int STACK_DEPTH = 16;
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DEPTH_W     = 5;
  localparam int VALUE_W     = 32;

  // front queue sizing
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // divider sizing
  localparam int DIV_STEPS = VALUE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_SLASH = 8'd47;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIV0  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_DIV,
    BK_FINISH
  } back_state_t;

  // classified word handed from the front to the back
  typedef struct packed {
    op_kind_t             kind;
    logic [VALUE_W-1:0]   push_value;
    logic                 eoe;
  } queue_word_t;

  // entry count reported in the 5-bit depth field, modulo 32
  function automatic logic [DEPTH_W-1:0] depth_field(input logic [PTR_W-1:0] cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    return wide[DEPTH_W-1:0];
  endfunction

endpackage

// ===== hdl/pfe_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_if: channel interfaces of the postfix evaluator
// Input channel carries characters, output channel carries stack reports.
// ----------------------------------------------------------------------------
interface pfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_expression;

  modport source (output valid, output symbol, output end_of_expression, input ready);
  modport sink   (input valid, input symbol, input end_of_expression, output ready);
endinterface

interface pfe_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] top_value;
  logic [4:0]         stack_depth;
  logic [1:0]         status;
  logic               expression_done;

  modport source (output valid, output top_value, output stack_depth, output status,
                  output expression_done, input ready);
  modport sink   (input valid, input top_value, input stack_depth, input status,
                  input expression_done, output ready);
endinterface

// ===== hdl/pfe_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/pfe_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle,
// quotient truncated toward zero. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module pfe_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pfe_pkg::VALUE_W-1:0]  numerator,
  input  logic [pfe_pkg::VALUE_W-1:0]  denominator,
  output logic                         done,
  output logic [pfe_pkg::VALUE_W-1:0]  quotient
);

  logic                           busy;
  logic [pfe_pkg::DIV_CNT_W-1:0]  cnt;
  logic [pfe_pkg::VALUE_W-1:0]    rem;
  logic [pfe_pkg::VALUE_W-1:0]    quo;
  logic [pfe_pkg::VALUE_W-1:0]    dvs;
  logic                           neg_q;

  logic [pfe_pkg::VALUE_W:0]      trial;
  logic [pfe_pkg::VALUE_W-1:0]    rem_next;
  logic [pfe_pkg::VALUE_W-1:0]    quo_next;
  logic [pfe_pkg::VALUE_W-1:0]    mag_n;
  logic [pfe_pkg::VALUE_W-1:0]    mag_d;

  // operand magnitudes
  assign mag_n = numerator[pfe_pkg::VALUE_W-1]   ? (~numerator + 1'b1)   : numerator;
  assign mag_d = denominator[pfe_pkg::VALUE_W-1] ? (~denominator + 1'b1) : denominator;

  // one restoring step
  always_comb begin
    trial = {rem, quo[pfe_pkg::VALUE_W-1]} - {1'b0, dvs};
    if (!trial[pfe_pkg::VALUE_W]) begin
      rem_next = trial[pfe_pkg::VALUE_W-1:0];
      quo_next = {quo[pfe_pkg::VALUE_W-2:0], 1'b1};
    end else begin
      rem_next = {rem[pfe_pkg::VALUE_W-2:0], quo[pfe_pkg::VALUE_W-1]};
      quo_next = {quo[pfe_pkg::VALUE_W-2:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == pfe_pkg::DIV_CNT_W'(pfe_pkg::DIV_STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == pfe_pkg::DIV_CNT_W'(pfe_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= mag_n;
      dvs   <= mag_d;
      neg_q <= numerator[pfe_pkg::VALUE_W-1] ^ denominator[pfe_pkg::VALUE_W-1];
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
      if (cnt == pfe_pkg::DIV_CNT_W'(pfe_pkg::DIV_STEPS - 1)) begin
        quotient <= neg_q ? (~quo_next + 1'b1) : quo_next;
      end
    end
  end

endmodule

// ===== hdl/pfe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_front: input side of the postfix evaluator
// Accepts characters, classifies them as push or operator and holds
// them in a short queue for the back end.
// ----------------------------------------------------------------------------
module pfe_front (
  input  logic                 clk,
  input  logic                 rst,
  pfe_in_if.sink               in_ch,
  output logic                 q_valid,
  output pfe_pkg::queue_word_t q_word,
  input  logic                 q_pop
);

  pfe_pkg::queue_word_t         slots [pfe_pkg::QUEUE_DEPTH];
  logic [pfe_pkg::QPTR_W-1:0]   wr_ptr;
  logic [pfe_pkg::QPTR_W-1:0]   rd_ptr;
  logic [pfe_pkg::QCNT_W-1:0]   count;
  pfe_pkg::queue_word_t         word_in;
  logic                         push;

  // classify the incoming character
  always_comb begin
    word_in.eoe        = in_ch.end_of_expression;
    word_in.push_value = 32'(in_ch.symbol) - 32'(pfe_pkg::CH_ZERO);
    if (in_ch.symbol == pfe_pkg::CH_PLUS) begin
      word_in.kind = pfe_pkg::OP_ADD;
    end else if (in_ch.symbol == pfe_pkg::CH_MINUS) begin
      word_in.kind = pfe_pkg::OP_SUB;
    end else if (in_ch.symbol == pfe_pkg::CH_STAR) begin
      word_in.kind = pfe_pkg::OP_MUL;
    end else if (in_ch.symbol == pfe_pkg::CH_SLASH) begin
      word_in.kind = pfe_pkg::OP_DIV;
    end else begin
      word_in.kind = pfe_pkg::OP_PUSH;
    end
  end

  assign in_ch.ready = (count != pfe_pkg::QCNT_W'(pfe_pkg::QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count != '0);
  assign q_word      = slots[rd_ptr];

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= word_in;
    end
  end

endmodule

// ===== hdl/pfe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_back: execution side of the postfix evaluator
// Keeps the top of stack in a register and the rest in a RAM, executes
// one queued word at a time and loads the output register.
// ----------------------------------------------------------------------------
module pfe_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  pfe_pkg::queue_word_t q_word,
  output logic                 q_pop,
  pfe_out_if.source            out_ch
);

  pfe_pkg::back_state_t          state, state_next;
  pfe_pkg::queue_word_t          cur;
  logic [pfe_pkg::PTR_W-1:0]     sp;
  logic [pfe_pkg::VALUE_W-1:0]   top;
  logic [pfe_pkg::VALUE_W-1:0]   res;
  pfe_pkg::status_t              status;

  logic [pfe_pkg::VALUE_W-1:0]   left;
  logic [pfe_pkg::PTR_W-1:0]     sp_m1;
  logic [pfe_pkg::PTR_W-1:0]     sp_m2;
  logic                          wr_en;
  logic                          div_start;
  logic                          div_done;
  logic [pfe_pkg::VALUE_W-1:0]   div_q;
  logic                          commit;
  logic                          under;
  logic                          full;
  logic [pfe_pkg::VALUE_W-1:0]   exec_res;
  pfe_pkg::status_t              exec_status;
  logic [pfe_pkg::PTR_W-1:0]     sp_new;

  logic                          out_valid;
  logic [pfe_pkg::VALUE_W-1:0]   out_top;
  logic [pfe_pkg::DEPTH_W-1:0]   out_depth;
  pfe_pkg::status_t              out_status;
  logic                          out_done;

  assign sp_m1 = sp - 1'b1;
  assign sp_m2 = sp - 2'd2;
  assign under = (sp < pfe_pkg::PTR_W'(2));
  assign full  = (sp == pfe_pkg::PTR_W'(pfe_pkg::STACK_DEPTH));

  // entries below the top live in the RAM
  pfe_ram #(
    .WIDTH (pfe_pkg::VALUE_W),
    .DEPTH (pfe_pkg::STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (sp_m1[pfe_pkg::IDX_W-1:0]),
    .wr_data (top),
    .rd_addr (sp_m2[pfe_pkg::IDX_W-1:0]),
    .rd_data (left)
  );

  pfe_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .numerator   (left),
    .denominator (top),
    .done        (div_done),
    .quotient    (div_q)
  );

  // operation result, left from the RAM and right from the top register
  always_comb begin
    exec_res    = '0;
    exec_status = pfe_pkg::ST_OK;
    unique case (cur.kind)
      pfe_pkg::OP_PUSH: begin
        exec_res = cur.push_value;
        if (full) begin
          exec_status = pfe_pkg::ST_OVER;
        end
      end
      pfe_pkg::OP_ADD: exec_res = left + top;
      pfe_pkg::OP_SUB: exec_res = left - top;
      pfe_pkg::OP_MUL: exec_res = left * top;
      pfe_pkg::OP_DIV: begin
        if (top == '0) begin
          exec_status = pfe_pkg::ST_DIV0;
        end
      end
      default: exec_res = '0;
    endcase
    if (cur.kind != pfe_pkg::OP_PUSH && under) begin
      exec_status = pfe_pkg::ST_UNDER;
    end
  end

  // new entry count on success
  assign sp_new = (cur.kind == pfe_pkg::OP_PUSH) ? (sp + 1'b1) : sp_m1;

  // sequencer
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    commit     = 1'b0;
    wr_en      = 1'b0;
    unique case (state)
      pfe_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = pfe_pkg::BK_EXEC;
        end
      end
      pfe_pkg::BK_EXEC: begin
        if (cur.kind == pfe_pkg::OP_DIV && exec_status == pfe_pkg::ST_OK) begin
          div_start  = 1'b1;
          state_next = pfe_pkg::BK_DIV;
        end else begin
          state_next = pfe_pkg::BK_FINISH;
        end
      end
      pfe_pkg::BK_DIV: begin
        if (div_done) begin
          state_next = pfe_pkg::BK_FINISH;
        end
      end
      pfe_pkg::BK_FINISH: begin
        if (!out_valid || out_ch.ready) begin
          commit     = 1'b1;
          state_next = pfe_pkg::BK_IDLE;
          wr_en      = (cur.kind == pfe_pkg::OP_PUSH) && (status == pfe_pkg::ST_OK)
                       && (sp != '0);
        end
      end
      default: state_next = pfe_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfe_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_word;
    end
    if (state == pfe_pkg::BK_EXEC) begin
      res    <= exec_res;
      status <= exec_status;
    end
    if (state == pfe_pkg::BK_DIV && div_done) begin
      res <= div_q;
    end
    if (commit && status == pfe_pkg::ST_OK) begin
      top <= res;
    end
  end

  // stack pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (commit) begin
      if (cur.eoe) begin
        sp <= '0;
      end else if (status == pfe_pkg::ST_OK) begin
        sp <= sp_new;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status <= status;
      out_done   <= cur.eoe;
      if (status == pfe_pkg::ST_OK) begin
        out_top   <= res;
        out_depth <= pfe_pkg::depth_field(sp_new);
      end else begin
        out_top   <= (sp != '0) ? top : '0;
        out_depth <= pfe_pkg::depth_field(sp);
      end
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.top_value       = out_top;
  assign out_ch.stack_depth     = out_depth;
  assign out_ch.status          = out_status;
  assign out_ch.expression_done = out_done;

endmodule

// ===== hdl/postfix_expression_evaluator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_unit: postfix expression evaluator
// Evaluates RPN characters on a bounded 32-bit operand stack.
//
//  channel  | direction | word contents
//  ---------+-----------+-----------------------------------------------------
//  in_ch    | in        | symbol, end_of_expression
//  out_ch   | out       | top_value, stack_depth, status, expression_done
//
// Push, add, subtract and multiply pass through execute and finish states
// to the output register; divide also waits on the 32-step iterative divider.
// Two words can wait in the input queue while the back end is busy.
// A result stalled on out_ch holds the back end in its final step.
// Reset empties the stack and the queue; the stack RAM is not cleared.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_unit (
  input  logic       clk,
  input  logic       rst,
  pfe_in_if.sink     in_ch,
  pfe_out_if.source  out_ch
);

  logic                 q_valid;
  pfe_pkg::queue_word_t q_word;
  logic                 q_pop;

  pfe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_pop   (q_pop)
  );

  pfe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== hdl/pfe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_checker: port-level checks of the postfix evaluator
// Watches the output channel for handshake and status consistency.
// ----------------------------------------------------------------------------
module pfe_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_depth,
  input logic [1:0]  out_status
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // underflow only reported with fewer than two entries
  a_under: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == pfe_pkg::ST_UNDER |-> out_depth < 5'd2)
    else $error("underflow with two or more entries");

  // overflow only reported on a full stack
  a_over: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == pfe_pkg::ST_OVER
      |-> out_depth == pfe_pkg::depth_field(pfe_pkg::PTR_W'(pfe_pkg::STACK_DEPTH)))
    else $error("overflow on a stack that is not full");

  // divide by zero needs two operands present
  a_div0: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == pfe_pkg::ST_DIV0 |-> out_depth >= 5'd2)
    else $error("divide by zero with fewer than two entries");

endmodule

bind postfix_expression_evaluator_unit pfe_checker u_pfe_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_depth  (out_ch.stack_depth),
  .out_status (out_ch.status)
);
